@@ rtl/core/tdtms_pkg.sv @@
`timescale 1ns / 1ps

package tdtms_pkg;

	// Field widths fixed by the item layout
	localparam int ADC_W   = 12;
	localparam int GAIN_W  = 16;
	localparam int SUM_W   = 16;
	localparam int CNT_W   = 4;
	localparam int STAT_W  = 3;
	localparam int CIDX_W  = 8;
	localparam int CDATA_W = 16;

	// Samples that make one coordinate
	localparam logic [CNT_W-1:0] SAMPLES_PER_POINT = 4'd10;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_UP      = 3'd0,
		ST_STARTED = 3'd1,
		ST_ACCEPT  = 3'd2,
		ST_READY   = 3'd3,
		ST_DROPPED = 3'd4
	} status_t;

	// Debounce phases
	typedef enum logic [2:0] {
		PH_FREE    = 3'b001,
		PH_WAITING = 3'b010,
		PH_PRESSED = 3'b100
	} phase_t;

	// Register indexes on the configuration channel
	localparam logic [CIDX_W-1:0] REG_TOUCH_ENABLE   = 8'd0;
	localparam logic [CIDX_W-1:0] REG_SWAP_AXES      = 8'd1;
	localparam logic [CIDX_W-1:0] REG_X_GAIN         = 8'd2;
	localparam logic [CIDX_W-1:0] REG_X_OFFSET       = 8'd3;
	localparam logic [CIDX_W-1:0] REG_Y_GAIN         = 8'd4;
	localparam logic [CIDX_W-1:0] REG_Y_OFFSET       = 8'd5;
	localparam logic [CIDX_W-1:0] REG_DISPLAY_WIDTH  = 8'd6;
	localparam logic [CIDX_W-1:0] REG_DISPLAY_HEIGHT = 8'd7;

	// Register reset values
	localparam logic signed [GAIN_W-1:0] GAIN_RST   = 16'sd16384;
	localparam logic [ADC_W-1:0]         WIDTH_RST  = 12'd240;
	localparam logic [ADC_W-1:0]         HEIGHT_RST = 12'd320;

endpackage

@@ rtl/core/tdtms_scale.sv @@
`timescale 1ns / 1ps

module tdtms_scale #(
	parameter int GAIN_FRAC_BITS = 14
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic        [tdtms_pkg::ADC_W-1:0]    filt,
	input  logic signed [tdtms_pkg::GAIN_W-1:0]   gain,
	input  logic signed [tdtms_pkg::GAIN_W-1:0]   offset,
	input  logic        [tdtms_pkg::ADC_W-1:0]    top,
	output logic        [tdtms_pkg::ADC_W-1:0]    pix
);

	localparam int PW = tdtms_pkg::ADC_W + 1 + tdtms_pkg::GAIN_W;
	localparam int QW = PW + 1;

	logic signed [PW-1:0] prod_s3;
	logic signed [QW-1:0] shifted;
	logic signed [QW-1:0] q;

	// Register the product of the trimmed mean and the signed gain
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PW'($signed({1'b0, filt})) * PW'(gain);
		end
	end

	// Floor shift, add offset, clamp to the display range
	always_comb begin
		shifted = QW'(prod_s3) >>> GAIN_FRAC_BITS;
		q       = shifted + QW'(offset);
		if (q < 0) begin
			pix = '0;
		end else if (q > $signed({{(QW-tdtms_pkg::ADC_W){1'b0}}, top})) begin
			pix = top;
		end else begin
			pix = q[tdtms_pkg::ADC_W-1:0];
		end
	end

endmodule

@@ rtl/core/touch_debounce_trimmed_mean_scaler_core.sv @@
`timescale 1ns / 1ps

// Resistive touch qualifier: debounce machine plus ten-sample trimmed mean.
// Input channel s_*: one word per tick (tuser 0) or converted sample pair
// (tuser 1). Output channel m_*: exactly one result word per input word,
// in order; tuser carries the status code.
// Configuration channel cfg_*: always ready, writes one register per
// handshake by index; indexes past the register list are ignored. Write it
// only while no word is in flight.
// Each word passes four register stages (state update, trimmed-mean subtract,
// gain multiply, offset and clamp).
// Throughput: one word per cycle while m_tready is high; each stage moves
// whenever the stage after it is empty or moving, so bubbles are squeezed out under back-pressure.
// Reset: debounce machine free, no collection, last pixels zero, registers
// at their reset values, pipeline empty.
// Stall: while m_tready is low the output word holds, the stages behind it
// fill up, and s_tready drops once all four are full.
module touch_debounce_trimmed_mean_scaler_core #(
	parameter int DEBOUNCE_TICKS = 2,
	parameter int ADC_BITS       = 12,
	parameter int GAIN_FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [31:0]                         s_tdata,   // pen_down, sample_chan_d0, sample_chan_90
	input  logic                                s_tuser,   // cmd
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [47:0]                         m_tdata,   // filtered_x, filtered_y, pixel_x, pixel_y
	output logic [tdtms_pkg::STAT_W-1:0]        m_tuser,   // status
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tdtms_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [tdtms_pkg::CDATA_W-1:0]       cfg_data
);

	localparam int AW   = tdtms_pkg::ADC_W;
	localparam int SW   = tdtms_pkg::SUM_W;
	localparam int CW   = tdtms_pkg::CNT_W;
	localparam int GW   = tdtms_pkg::GAIN_W;
	localparam int DCW  = $clog2(DEBOUNCE_TICKS + 2);
	localparam logic [AW-1:0]  AMASK    = AW'((1 << ADC_BITS) - 1);
	localparam logic [DCW-1:0] DB_TICKS = DCW'(DEBOUNCE_TICKS);
	localparam logic [CW-1:0]  LAST_IDX = tdtms_pkg::SAMPLES_PER_POINT - CW'(1);

	// Configuration registers
	logic                 enable_q;
	logic                 swap_q;
	logic signed [GW-1:0] x_gain_q;
	logic signed [GW-1:0] x_off_q;
	logic signed [GW-1:0] y_gain_q;
	logic signed [GW-1:0] y_off_q;
	logic [AW-1:0]        disp_w_q;
	logic [AW-1:0]        disp_h_q;

	// Block state
	tdtms_pkg::phase_t phase_q, n_phase;
	logic [DCW-1:0]    dcnt_q, n_dcnt;
	logic              collecting_q, n_collecting;
	logic [CW-1:0]     cnt_q, n_cnt;
	logic [SW-1:0]     sum_x_q, sum_y_q, n_sum_x, n_sum_y;
	logic [AW-1:0]     min_x_q, max_x_q, min_y_q, max_y_q;
	logic [AW-1:0]     n_min_x, n_max_x, n_min_y, n_max_y;
	logic [AW-1:0]     last_px_q, last_py_q;
	tdtms_pkg::status_t n_status;

	// Pipeline
	logic               v_s1, v_s2, v_s3, v_q;
	logic               r2, r3, r4;
	logic               acc;
	tdtms_pkg::status_t status_s1, status_s2, status_s3, status_q;
	logic [SW-1:0]      sum_x_s1, sum_y_s1;
	logic [AW:0]        mm_x_s1, mm_y_s1;
	logic [SW-1:0]      diff_x, diff_y;
	logic [AW-1:0]      fx_s2, fy_s2, fx_s3, fy_s3, fx_q, fy_q;
	logic [AW-1:0]      pix_x, pix_y;

	logic          pen;
	logic [AW-1:0] sd0, s90, vx, vy;

	assign cfg_ready = 1'b1;

	// Stage readiness: move when the next stage is empty or moving
	assign r4       = !v_q || m_tready;
	assign r3       = !v_s3 || r4;
	assign r2       = !v_s2 || r3;
	assign s_tready = !v_s1 || r2;
	assign acc      = s_tvalid && s_tready;

	assign pen = s_tdata[0];
	assign sd0 = s_tdata[12:1] & AMASK;
	assign s90 = s_tdata[24:13] & AMASK;
	assign vx  = swap_q ? s90 : sd0;
	assign vy  = swap_q ? sd0 : s90;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			swap_q   <= 1'b0;
			x_gain_q <= tdtms_pkg::GAIN_RST;
			x_off_q  <= '0;
			y_gain_q <= tdtms_pkg::GAIN_RST;
			y_off_q  <= '0;
			disp_w_q <= tdtms_pkg::WIDTH_RST;
			disp_h_q <= tdtms_pkg::HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				tdtms_pkg::REG_TOUCH_ENABLE:   enable_q <= cfg_data[0];
				tdtms_pkg::REG_SWAP_AXES:      swap_q   <= cfg_data[0];
				tdtms_pkg::REG_X_GAIN:         x_gain_q <= $signed(cfg_data);
				tdtms_pkg::REG_X_OFFSET:       x_off_q  <= $signed(cfg_data);
				tdtms_pkg::REG_Y_GAIN:         y_gain_q <= $signed(cfg_data);
				tdtms_pkg::REG_Y_OFFSET:       y_off_q  <= $signed(cfg_data);
				tdtms_pkg::REG_DISPLAY_WIDTH:  disp_w_q <= cfg_data[AW-1:0];
				tdtms_pkg::REG_DISPLAY_HEIGHT: disp_h_q <= cfg_data[AW-1:0];
				default: ;
			endcase
		end
	end

	// Next state for one accepted word: debounce step or sample accumulate
	always_comb begin
		n_phase      = phase_q;
		n_dcnt       = dcnt_q;
		n_collecting = collecting_q;
		n_cnt        = cnt_q;
		n_sum_x      = sum_x_q;
		n_sum_y      = sum_y_q;
		n_min_x      = min_x_q;
		n_max_x      = max_x_q;
		n_min_y      = min_y_q;
		n_max_y      = max_y_q;
		n_status     = tdtms_pkg::ST_UP;
		if (!s_tuser) begin
			if (enable_q) begin
				case (phase_q)
					tdtms_pkg::PH_WAITING: begin
						if (pen) begin
							if (dcnt_q >= DB_TICKS) begin
								n_dcnt  = DCW'(1);
								n_phase = tdtms_pkg::PH_PRESSED;
							end else begin
								n_dcnt = dcnt_q + DCW'(1);
							end
						end else begin
							n_dcnt  = DCW'(1);
							n_phase = tdtms_pkg::PH_FREE;
						end
					end
					tdtms_pkg::PH_PRESSED:
						n_phase = pen ? tdtms_pkg::PH_PRESSED : tdtms_pkg::PH_FREE;
					tdtms_pkg::PH_FREE:
						n_phase = pen ? tdtms_pkg::PH_WAITING : tdtms_pkg::PH_FREE;
					default: n_phase = tdtms_pkg::PH_FREE;
				endcase
			end
			if (enable_q && n_phase == tdtms_pkg::PH_PRESSED) begin
				n_collecting = 1'b1;
				n_cnt        = '0;
				n_sum_x      = '0;
				n_sum_y      = '0;
				n_min_x      = '0;
				n_max_x      = '0;
				n_min_y      = '0;
				n_max_y      = '0;
				n_status     = tdtms_pkg::ST_STARTED;
			end else begin
				n_collecting = 1'b0;
			end
		end else if (!collecting_q || !pen) begin
			n_collecting = 1'b0;
			n_status     = tdtms_pkg::ST_DROPPED;
		end else begin
			if (cnt_q == '0) begin
				n_min_x = vx;
				n_max_x = vx;
				n_min_y = vy;
				n_max_y = vy;
				n_sum_x = SW'(vx);
				n_sum_y = SW'(vy);
			end else begin
				if (vx < min_x_q) n_min_x = vx;
				if (vx > max_x_q) n_max_x = vx;
				if (vy < min_y_q) n_min_y = vy;
				if (vy > max_y_q) n_max_y = vy;
				n_sum_x = sum_x_q + SW'(vx);
				n_sum_y = sum_y_q + SW'(vy);
			end
			if (cnt_q >= LAST_IDX) begin
				n_collecting = 1'b0;
				n_cnt        = '0;
				n_status     = tdtms_pkg::ST_READY;
			end else begin
				n_cnt    = cnt_q + CW'(1);
				n_status = tdtms_pkg::ST_ACCEPT;
			end
		end
	end

	// Commit state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= tdtms_pkg::PH_FREE;
			dcnt_q       <= DCW'(1);
			collecting_q <= 1'b0;
			cnt_q        <= '0;
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			min_x_q      <= '0;
			max_x_q      <= '0;
			min_y_q      <= '0;
			max_y_q      <= '0;
		end else if (acc) begin
			phase_q      <= n_phase;
			dcnt_q       <= n_dcnt;
			collecting_q <= n_collecting;
			cnt_q        <= n_cnt;
			sum_x_q      <= n_sum_x;
			sum_y_q      <= n_sum_y;
			min_x_q      <= n_min_x;
			max_x_q      <= n_max_x;
			min_y_q      <= n_min_y;
			max_y_q      <= n_max_y;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (s_tready) v_s1 <= s_tvalid;
			if (r2)       v_s2 <= v_s1;
			if (r3)       v_s3 <= v_s2;
			if (r4)       v_q  <= v_s3;
		end
	end

	// Stage 1: snapshot sums and min plus max
	always_ff @(posedge clk) begin
		if (s_tready) begin
			status_s1 <= n_status;
			sum_x_s1  <= n_sum_x;
			sum_y_s1  <= n_sum_y;
			mm_x_s1   <= {1'b0, n_min_x} + {1'b0, n_max_x};
			mm_y_s1   <= {1'b0, n_min_y} + {1'b0, n_max_y};
		end
	end

	// Stage 2: trimmed mean, zero unless the coordinate is complete
	assign diff_x = sum_x_s1 - SW'(mm_x_s1);
	assign diff_y = sum_y_s1 - SW'(mm_y_s1);

	always_ff @(posedge clk) begin
		if (r2) begin
			status_s2 <= status_s1;
			fx_s2     <= (status_s1 == tdtms_pkg::ST_READY) ? diff_x[AW+2:3] : '0;
			fy_s2     <= (status_s1 == tdtms_pkg::ST_READY) ? diff_y[AW+2:3] : '0;
		end
	end

	// Stage 3: gain product held inside the scalers
	always_ff @(posedge clk) begin
		if (r3) begin
			status_s3 <= status_s2;
			fx_s3     <= fx_s2;
			fy_s3     <= fy_s2;
		end
	end

	tdtms_scale #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_scale_x (
		.clk    (clk),
		.en     (r3),
		.filt   (fx_s2),
		.gain   (x_gain_q),
		.offset (x_off_q),
		.top    (disp_w_q),
		.pix    (pix_x)
	);

	tdtms_scale #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_scale_y (
		.clk    (clk),
		.en     (r3),
		.filt   (fy_s2),
		.gain   (y_gain_q),
		.offset (y_off_q),
		.top    (disp_h_q),
		.pix    (pix_y)
	);

	// Output word; the last pixel pair advances only with a complete coordinate
	always_ff @(posedge clk) begin
		if (r4) begin
			status_q <= status_s3;
			fx_q     <= fx_s3;
			fy_q     <= fy_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_px_q <= '0;
			last_py_q <= '0;
		end else if (r4 && v_s3 && status_s3 == tdtms_pkg::ST_READY) begin
			last_px_q <= pix_x;
			last_py_q <= pix_y;
		end
	end

	assign m_tvalid = v_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {last_py_q, last_px_q, fy_q, fx_q};

	// A collection only runs while the debounce machine is pressed
	a_collect_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> phase_q == tdtms_pkg::PH_PRESSED)
		else $error("collection active outside pressed phase");

	// The sample counter never reaches the point size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < tdtms_pkg::SAMPLES_PER_POINT)
		else $error("sample counter out of range");

	// Filtered fields are zero unless a coordinate is reported
	a_filt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != tdtms_pkg::ST_READY |-> m_tdata[2*AW-1:0] == '0)
		else $error("filtered value leaked on non-coordinate word");

	// A reported coordinate lies inside the display
	a_pix_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == tdtms_pkg::ST_READY |->
		m_tdata[3*AW-1:2*AW] <= disp_w_q && m_tdata[4*AW-1:3*AW] <= disp_h_q)
		else $error("pixel coordinate beyond display size");

endmodule
